// ===== design/sht_pkg.sv =====
package sht_pkg;

  localparam int MAX_CHARS  = 31;
  localparam int NAME_W     = MAX_CHARS * 8;
  localparam int IDX_W      = 10;
  localparam int VALUE_W    = 32;
  localparam int CODE_W     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_TYPE_CODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNDEFINED_VALUE  = 1'd1;

  localparam logic [CODE_W-1:0]  RESET_SYMBOL_TYPE = 4'd2;
  localparam logic [VALUE_W-1:0] RESET_UNDEF_VALUE = 32'd0;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_SEARCH = 2'd1,
    FUNC_SET    = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    STATUS_FOUND     = 3'd0,
    STATUS_INSERTED  = 3'd1,
    STATUS_NOT_FOUND = 3'd2,
    STATUS_FULL      = 3'd3,
    STATUS_BAD_INDEX = 3'd4,
    STATUS_EMPTY     = 3'd5
  } status_e;

  typedef struct packed {
    logic [NAME_W-1:0]  name;
    logic [VALUE_W-1:0] value;
    logic [CODE_W-1:0]  typ;
    logic [CODE_W-1:0]  arg;
  } slot_t;

  typedef struct packed {
    status_e            status;
    logic [IDX_W-1:0]   found_index;
    logic [VALUE_W-1:0] slot_value;
    logic [CODE_W-1:0]  slot_type;
    logic [CODE_W-1:0]  slot_arg_class;
  } result_t;

endpackage

// ===== design/sht_if.sv =====
interface sht_req_if;
  logic                  valid;
  logic                  ready;
  sht_pkg::func_e        func;
  logic [63:0]           name_word0;
  logic [63:0]           name_word1;
  logic [63:0]           name_word2;
  logic [55:0]           name_word3;
  logic [9:0]            slot_index;
  logic signed [31:0]    new_value;
  logic [3:0]            new_type;
  logic [3:0]            new_arg_class;

  modport source (
    output valid, func, name_word0, name_word1, name_word2, name_word3,
           slot_index, new_value, new_type, new_arg_class,
    input  ready
  );
  modport sink (
    input  valid, func, name_word0, name_word1, name_word2, name_word3,
           slot_index, new_value, new_type, new_arg_class,
    output ready
  );
endinterface

interface sht_rsp_if;
  logic                  valid;
  logic                  ready;
  sht_pkg::status_e      status;
  logic [9:0]            found_index;
  logic signed [31:0]    slot_value;
  logic [3:0]            slot_type;
  logic [3:0]            slot_arg_class;

  modport source (
    output valid, status, found_index, slot_value, slot_type, slot_arg_class,
    input  ready
  );
  modport sink (
    input  valid, status, found_index, slot_value, slot_type, slot_arg_class,
    output ready
  );
endinterface

// ===== design/sht_ram.sv =====
module sht_ram #(
  parameter int WIDTH = 288,
  parameter int DEPTH = 1021
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/symbol_hash_table.sv =====
// Channel   Dir  Modport  Word
// req_i     in   sink     func, name_word0..3, slot_index, new_value, new_type, new_arg_class
// rsp_o     out  source   status, found_index, slot_value, slot_type, slot_arg_class
// cfg_*     in   -        write enable, register index, write data
//
// Set and read pass a start step and a slot read before the result; a bad index or an empty
// name is answered from the start step. Insert and search sum the L name characters four a
// cycle, take S+1 restoring steps for the home slot (3 at 1021 slots), then make P probes of
// one slot read and one compare each through the single table RAM.
// After reset a clearing pass writes every slot, with req_i not ready.
// A result waits in the output register; a finishing step holds until it drains.
module symbol_hash_table #(
  parameter int TABLE_SIZE = 1021,
  parameter int NAME_CHARS = 31
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  sht_req_if.sink                           req_i,
  sht_rsp_if.source                         rsp_o,
  input  logic                              cfg_we_i,
  input  logic [sht_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sht_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  function automatic int mod_shift(int size, int smax);
    int k;
    k = 0;
    while ((size << (k + 1)) <= smax) begin
      k++;
    end
    return k;
  endfunction

  localparam int AW        = $clog2(TABLE_SIZE);
  localparam int NW        = $clog2(TABLE_SIZE + 1);
  localparam int HALF      = TABLE_SIZE / 2;
  localparam int CW        = $clog2(HALF + 1);
  localparam int SUM_MAX   = NAME_CHARS * 255;
  localparam int SW        = $clog2(SUM_MAX + 1);
  localparam int MSH       = mod_shift(TABLE_SIZE, SUM_MAX);
  localparam int DIV_INT   = TABLE_SIZE * (2 ** MSH);
  localparam int DW        = $clog2(DIV_INT + 1);
  localparam int RW        = (SW > DW) ? SW : DW;
  localparam int IW        = sht_pkg::IDX_W;
  localparam int NMW       = sht_pkg::NAME_W;
  localparam int ENTRY_W   = $bits(sht_pkg::slot_t);

  localparam logic [RW-1:0] DIV_INIT = RW'(DIV_INT);
  localparam logic [RW-1:0] TS_R     = RW'(TABLE_SIZE);
  localparam logic [AW-1:0] LAST_POS = AW'(TABLE_SIZE - 1);
  localparam logic [NW-1:0] LAST_N   = NW'(TABLE_SIZE - 1);
  localparam logic [CW-1:0] HALF_C   = CW'(HALF);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_SUM,
    S_MOD,
    S_READ,
    S_CHECK,
    S_ATTR
  } state_e;

  state_e                          state_q, state_d;
  logic [AW-1:0]                   clr_q, clr_d;
  sht_pkg::func_e                  func_q, func_d;
  logic [NMW-1:0]                  key_q, key_d;
  logic [NMW-1:0]                  sh_q, sh_d;
  logic [RW-1:0]                   acc_q, acc_d;
  logic [RW-1:0]                   div_q, div_d;
  logic [AW-1:0]                   pos_q, pos_d;
  logic [NW-1:0]                   n_q, n_d;
  logic [IW-1:0]                   idx_q, idx_d;
  logic [sht_pkg::VALUE_W-1:0]     nv_q, nv_d;
  logic [sht_pkg::CODE_W-1:0]      nt_q, nt_d;
  logic [sht_pkg::CODE_W-1:0]      na_q, na_d;
  logic [CW-1:0]                   count_q, count_d;
  logic [sht_pkg::CODE_W-1:0]      cfg_type_q, cfg_type_d;
  logic [sht_pkg::VALUE_W-1:0]     cfg_undef_q, cfg_undef_d;
  logic                            ov_q, ov_d;
  sht_pkg::result_t                res_q, res_d;

  logic [NMW-1:0]                  raw;
  logic [NMW-1:0]                  key_n;
  logic                            live;
  logic [9:0]                      sum4;
  logic [RW-1:0]                   mod_rem;
  logic                            out_free;
  logic                            emit;
  sht_pkg::result_t                res;
  logic                            ram_we;
  logic                            ram_re;
  logic [AW-1:0]                   ram_waddr;
  logic [AW-1:0]                   ram_raddr;
  sht_pkg::slot_t                  ram_wdata;
  sht_pkg::slot_t                  rd;

  sht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd)
  );

  // Keep the characters up to the first zero byte
  always_comb begin
    raw   = {req_i.name_word3, req_i.name_word2, req_i.name_word1, req_i.name_word0};
    key_n = '0;
    live  = 1'b1;
    for (int i = 0; i < sht_pkg::MAX_CHARS; i++) begin
      if (i >= NAME_CHARS || raw[8*i +: 8] == 8'd0) begin
        live = 1'b0;
      end
      if (live) begin
        key_n[8*i +: 8] = raw[8*i +: 8];
      end
    end
  end

  assign sum4 = 10'(sh_q[7:0]) + 10'(sh_q[15:8]) + 10'(sh_q[23:16]) + 10'(sh_q[31:24]);
  assign mod_rem  = (acc_q >= div_q) ? acc_q - div_q : acc_q;
  assign out_free = !ov_q || rsp_o.ready;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    func_d      = func_q;
    key_d       = key_q;
    sh_d        = sh_q;
    acc_d       = acc_q;
    div_d       = div_q;
    pos_d       = pos_q;
    n_d         = n_q;
    idx_d       = idx_q;
    nv_d        = nv_q;
    nt_d        = nt_q;
    na_d        = na_q;
    count_d     = count_q;
    cfg_type_d  = cfg_type_q;
    cfg_undef_d = cfg_undef_q;
    ov_d        = ov_q && !rsp_o.ready;
    res_d       = res_q;
    emit        = 1'b0;
    res         = '0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = pos_q;
    ram_raddr   = pos_q;
    ram_wdata   = '0;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        sht_pkg::CFG_SYMBOL_TYPE_CODE: cfg_type_d  = cfg_data_i[sht_pkg::CODE_W-1:0];
        sht_pkg::CFG_UNDEFINED_VALUE:  cfg_undef_d = cfg_data_i[sht_pkg::VALUE_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        if (clr_q == LAST_POS) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          func_d  = req_i.func;
          key_d   = key_n;
          sh_d    = key_n;
          acc_d   = '0;
          idx_d   = req_i.slot_index;
          nv_d    = req_i.new_value;
          nt_d    = req_i.new_type;
          na_d    = req_i.new_arg_class;
          state_d = S_START;
        end
      end
      S_START: begin
        if (func_q == sht_pkg::FUNC_SET || func_q == sht_pkg::FUNC_READ) begin
          if (int'(idx_q) >= TABLE_SIZE) begin
            if (out_free) begin
              emit       = 1'b1;
              res.status = sht_pkg::STATUS_BAD_INDEX;
              state_d    = S_IDLE;
            end
          end else begin
            ram_re    = 1'b1;
            ram_raddr = AW'(idx_q);
            pos_d     = AW'(idx_q);
            state_d   = S_ATTR;
          end
        end else if (key_q[7:0] == 8'd0) begin
          if (out_free) begin
            emit       = 1'b1;
            res.status = sht_pkg::STATUS_EMPTY;
            state_d    = S_IDLE;
          end
        end else begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        acc_d = acc_q + RW'(sum4);
        sh_d  = sh_q >> 32;
        if ((sh_q >> 32) == '0) begin
          div_d   = DIV_INIT;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        acc_d = mod_rem;
        div_d = div_q >> 1;
        if (div_q == TS_R) begin
          pos_d   = AW'(mod_rem);
          n_d     = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        ram_re  = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (rd.name == key_q) begin
          if (out_free) begin
            emit               = 1'b1;
            res.status         = sht_pkg::STATUS_FOUND;
            res.found_index    = IW'(pos_q);
            res.slot_value     = rd.value;
            res.slot_type      = rd.typ;
            res.slot_arg_class = rd.arg;
            state_d            = S_IDLE;
          end
        end else if (rd.name[7:0] == 8'd0) begin
          if (out_free) begin
            emit    = 1'b1;
            state_d = S_IDLE;
            if (func_q == sht_pkg::FUNC_SEARCH) begin
              res.status = sht_pkg::STATUS_NOT_FOUND;
            end else if (count_q >= HALF_C) begin
              res.status = sht_pkg::STATUS_FULL;
            end else begin
              ram_we             = 1'b1;
              ram_wdata.name     = key_q;
              ram_wdata.value    = cfg_undef_q;
              ram_wdata.typ      = cfg_type_q;
              ram_wdata.arg      = rd.arg;
              count_d            = count_q + CW'(1);
              res.status         = sht_pkg::STATUS_INSERTED;
              res.found_index    = IW'(pos_q);
              res.slot_value     = cfg_undef_q;
              res.slot_type      = cfg_type_q;
              res.slot_arg_class = rd.arg;
            end
          end
        end else if (n_q == LAST_N) begin
          if (out_free) begin
            emit       = 1'b1;
            res.status = (func_q == sht_pkg::FUNC_SEARCH) ? sht_pkg::STATUS_NOT_FOUND
                                                          : sht_pkg::STATUS_FULL;
            state_d    = S_IDLE;
          end
        end else begin
          pos_d   = (pos_q == LAST_POS) ? '0 : pos_q + AW'(1);
          n_d     = n_q + NW'(1);
          state_d = S_READ;
        end
      end
      S_ATTR: begin
        if (out_free) begin
          emit            = 1'b1;
          res.status      = sht_pkg::STATUS_FOUND;
          res.found_index = IW'(pos_q);
          state_d         = S_IDLE;
          if (func_q == sht_pkg::FUNC_SET) begin
            ram_we             = 1'b1;
            ram_wdata.name     = rd.name;
            ram_wdata.value    = nv_q;
            ram_wdata.typ      = nt_q;
            ram_wdata.arg      = na_q;
            res.slot_value     = nv_q;
            res.slot_type      = nt_q;
            res.slot_arg_class = na_q;
          end else begin
            res.slot_value     = rd.value;
            res.slot_type      = rd.typ;
            res.slot_arg_class = rd.arg;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (emit) begin
      ov_d  = 1'b1;
      res_d = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      func_q      <= sht_pkg::FUNC_INSERT;
      key_q       <= '0;
      sh_q        <= '0;
      acc_q       <= '0;
      div_q       <= '0;
      pos_q       <= '0;
      n_q         <= '0;
      idx_q       <= '0;
      nv_q        <= '0;
      nt_q        <= '0;
      na_q        <= '0;
      count_q     <= '0;
      cfg_type_q  <= sht_pkg::RESET_SYMBOL_TYPE;
      cfg_undef_q <= sht_pkg::RESET_UNDEF_VALUE;
      ov_q        <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      func_q      <= func_d;
      key_q       <= key_d;
      sh_q        <= sh_d;
      acc_q       <= acc_d;
      div_q       <= div_d;
      pos_q       <= pos_d;
      n_q         <= n_d;
      idx_q       <= idx_d;
      nv_q        <= nv_d;
      nt_q        <= nt_d;
      na_q        <= na_d;
      count_q     <= count_d;
      cfg_type_q  <= cfg_type_d;
      cfg_undef_q <= cfg_undef_d;
      ov_q        <= ov_d;
      res_q       <= res_d;
    end
  end

  assign req_i.ready          = (state_q == S_IDLE);
  assign rsp_o.valid          = ov_q;
  assign rsp_o.status         = res_q.status;
  assign rsp_o.found_index    = res_q.found_index;
  assign rsp_o.slot_value     = res_q.slot_value;
  assign rsp_o.slot_type      = res_q.slot_type;
  assign rsp_o.slot_arg_class = res_q.slot_arg_class;

endmodule

// ===== design/sht_checker.sv =====
module sht_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input sht_pkg::status_e rsp_status_i,
  input logic [9:0]       rsp_found_index_i,
  input logic [31:0]      rsp_slot_value_i,
  input logic [3:0]       rsp_slot_type_i,
  input logic [3:0]       rsp_slot_arg_class_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result word dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_status_i) && $stable(rsp_found_index_i)
      && $stable(rsp_slot_value_i))
    else $error("stalled result word changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while previous word still in progress");

  a_miss_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == sht_pkg::STATUS_NOT_FOUND
      || rsp_status_i == sht_pkg::STATUS_FULL || rsp_status_i == sht_pkg::STATUS_BAD_INDEX
      || rsp_status_i == sht_pkg::STATUS_EMPTY)
    |-> rsp_found_index_i == 10'd0 && rsp_slot_value_i == 32'd0
      && rsp_slot_type_i == 4'd0 && rsp_slot_arg_class_i == 4'd0)
    else $error("refused result carries slot contents");

endmodule

bind symbol_hash_table sht_checker u_sht_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .req_valid_i          (req_i.valid),
  .req_ready_i          (req_i.ready),
  .rsp_valid_i          (rsp_o.valid),
  .rsp_ready_i          (rsp_o.ready),
  .rsp_status_i         (rsp_o.status),
  .rsp_found_index_i    (rsp_o.found_index),
  .rsp_slot_value_i     (rsp_o.slot_value),
  .rsp_slot_type_i      (rsp_o.slot_type),
  .rsp_slot_arg_class_i (rsp_o.slot_arg_class)
);

// ===== dv/tb_symbol_hash_table.sv =====
`timescale 1ns / 1ps

module tb_symbol_hash_table;

  localparam int TBL   = 1021;
  localparam int LIMIT = 6_000_000;

  typedef struct {
    sht_pkg::func_e   func;
    logic [63:0]      name0;
    logic [63:0]      name1;
    logic [63:0]      name2;
    logic [55:0]      name3;
    logic [9:0]       idx;
    logic [31:0]      value;
    logic [3:0]       typ;
    logic [3:0]       arg;
    bit               typed;
    sht_pkg::result_t want;
  } sym_req_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                           cfg_we_i;
  logic [sht_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [sht_pkg::CFG_DATA_W-1:0] cfg_data_i;

  sht_req_if req ();
  sht_rsp_if rsp ();

  symbol_hash_table #(
    .TABLE_SIZE (TBL),
    .NAME_CHARS (sht_pkg::MAX_CHARS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rsp_o       (rsp),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [sht_pkg::NAME_W-1:0]  slot_names  [TBL];
  logic [sht_pkg::VALUE_W-1:0] slot_values [TBL];
  logic [sht_pkg::CODE_W-1:0]  slot_types  [TBL];
  logic [sht_pkg::CODE_W-1:0]  slot_args   [TBL];
  int                          sym_count;
  logic [sht_pkg::CODE_W-1:0]  new_sym_type;
  logic [sht_pkg::VALUE_W-1:0] new_sym_value;

  sht_pkg::result_t           pending[$];
  sym_req_t                   plan_q[$];
  logic [sht_pkg::NAME_W-1:0] known[$];
  int                         mismatches;
  int                         cycles;
  bit                         calm_tx;
  bit                         calm_rx;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int pick_wait(inout bit calm);
    if ($urandom_range(0, 19) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic sht_pkg::result_t mk_res(sht_pkg::status_e st, int idx, logic [31:0] v,
                                              int t, int a);
    sht_pkg::result_t r;
    r.status         = st;
    r.found_index    = 10'(idx);
    r.slot_value     = v;
    r.slot_type      = 4'(t);
    r.slot_arg_class = 4'(a);
    return r;
  endfunction

  // keep characters up to the first zero byte
  function automatic logic [sht_pkg::NAME_W-1:0] trim_name(logic [sht_pkg::NAME_W-1:0] raw,
                                                           output int sum);
    logic [sht_pkg::NAME_W-1:0] nm;
    int i;
    nm  = '0;
    i   = 0;
    sum = 0;
    while (i < sht_pkg::MAX_CHARS && raw[i*8+:8] != 8'd0) begin
      nm[i*8+:8] = raw[i*8+:8];
      sum += raw[i*8+:8];
      i++;
    end
    return nm;
  endfunction

  function automatic sht_pkg::result_t slot_result(sht_pkg::status_e st, int s);
    return mk_res(st, s, slot_values[s], slot_types[s], slot_args[s]);
  endfunction

  function automatic sht_pkg::result_t table_step(sym_req_t w);
    logic [sht_pkg::NAME_W-1:0] nm;
    int sum, s, n;
    bit hit, hole;
    if (w.func == sht_pkg::FUNC_INSERT || w.func == sht_pkg::FUNC_SEARCH) begin
      nm = trim_name({w.name3, w.name2, w.name1, w.name0}, sum);
      if (nm[7:0] == 8'd0) return mk_res(sht_pkg::STATUS_EMPTY, 0, '0, 0, 0);
      s    = sum % TBL;
      hit  = 1'b0;
      hole = 1'b0;
      for (n = 0; n < TBL && !hit && !hole; n++) begin
        if (slot_names[s] == nm) hit = 1'b1;
        else if (slot_names[s][7:0] == 8'd0) hole = 1'b1;
        else s = (s + 1 == TBL) ? 0 : s + 1;
      end
      if (hit) return slot_result(sht_pkg::STATUS_FOUND, s);
      if (w.func == sht_pkg::FUNC_SEARCH) return mk_res(sht_pkg::STATUS_NOT_FOUND, 0, '0, 0, 0);
      if (!hole || sym_count + 1 > TBL / 2) return mk_res(sht_pkg::STATUS_FULL, 0, '0, 0, 0);
      sym_count++;
      slot_names[s]  = nm;
      slot_types[s]  = new_sym_type;
      slot_values[s] = new_sym_value;
      return slot_result(sht_pkg::STATUS_INSERTED, s);
    end
    if (w.idx >= TBL) return mk_res(sht_pkg::STATUS_BAD_INDEX, 0, '0, 0, 0);
    if (w.func == sht_pkg::FUNC_SET) begin
      slot_values[w.idx] = w.value;
      slot_types[w.idx]  = w.typ;
      slot_args[w.idx]   = w.arg;
    end
    return slot_result(sht_pkg::STATUS_FOUND, w.idx);
  endfunction

  function automatic logic [sht_pkg::NAME_W-1:0] fresh_name();
    logic [sht_pkg::NAME_W-1:0] nm;
    int len;
    int r;
    nm  = '0;
    r   = $urandom_range(0, 99);
    len = r < 3 ? 0 : r < 13 ? sht_pkg::MAX_CHARS
        : r < 25 ? $urandom_range(9, 30) : $urandom_range(1, 8);
    for (int i = 0; i < len; i++) nm[i*8+:8] = 8'($urandom_range(1, 255));
    if (len > 0) known.push_back(nm);
    return nm;
  endfunction

  // at random, fill the bytes past the terminator with junk
  function automatic logic [sht_pkg::NAME_W-1:0] add_tail(logic [sht_pkg::NAME_W-1:0] nm);
    int p;
    p = 0;
    while (p < sht_pkg::MAX_CHARS && nm[p*8+:8] != 8'd0) p++;
    if (p < sht_pkg::MAX_CHARS - 1 && $urandom_range(0, 2) == 0)
      for (int i = p + 1; i < sht_pkg::MAX_CHARS; i++) nm[i*8+:8] = 8'($urandom);
    return nm;
  endfunction

  function automatic sym_req_t rand_req(bit filling);
    sym_req_t w;
    int r;
    logic [sht_pkg::NAME_W-1:0] raw;
    r = $urandom_range(0, 99);
    if (filling)
      w.func = r < 85 ? sht_pkg::FUNC_INSERT : r < 90 ? sht_pkg::FUNC_SEARCH
             : r < 95 ? sht_pkg::FUNC_SET : sht_pkg::FUNC_READ;
    else
      w.func = r < 35 ? sht_pkg::FUNC_INSERT : r < 65 ? sht_pkg::FUNC_SEARCH
             : r < 80 ? sht_pkg::FUNC_SET : sht_pkg::FUNC_READ;
    if (known.size() > 0 && $urandom_range(0, 99) < (filling ? 10 : 50))
      raw = known[$urandom_range(0, known.size() - 1)];
    else
      raw = fresh_name();
    {w.name3, w.name2, w.name1, w.name0} = add_tail(raw);
    w.idx   = ($urandom_range(0, 19) == 0) ? 10'($urandom_range(TBL, 1023))
                                           : 10'($urandom_range(0, 1023));
    w.value = $urandom;
    w.typ   = 4'($urandom);
    w.arg   = 4'($urandom);
    w.typed = 1'b0;
    w.want  = '0;
    return w;
  endfunction

  task automatic add_name(sht_pkg::func_e f, logic [sht_pkg::NAME_W-1:0] raw);
    sym_req_t w;
    w.func = f;
    {w.name3, w.name2, w.name1, w.name0} = raw;
    w.idx   = 10'($urandom);
    w.value = $urandom;
    w.typ   = 4'($urandom);
    w.arg   = 4'($urandom);
    w.typed = 1'b0;
    w.want  = '0;
    plan_q.push_back(w);
  endtask

  task automatic add_slot(sht_pkg::func_e f, int idx, logic [31:0] v, int t, int a);
    sym_req_t w;
    w.func  = f;
    w.name0 = {$urandom, $urandom};
    w.name1 = {$urandom, $urandom};
    w.name2 = {$urandom, $urandom};
    w.name3 = 56'({$urandom, $urandom});
    w.idx   = 10'(idx);
    w.value = v;
    w.typ   = 4'(t);
    w.arg   = 4'(a);
    w.typed = 1'b0;
    w.want  = '0;
    plan_q.push_back(w);
  endtask

  task automatic pin_last(sht_pkg::result_t r);
    plan_q[plan_q.size() - 1].typed = 1'b1;
    plan_q[plan_q.size() - 1].want  = r;
  endtask

  task automatic push_req(sym_req_t w);
    int gap;
    sht_pkg::result_t pred;
    gap = pick_wait(calm_tx);
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.func          = w.func;
    req.name_word0    = w.name0;
    req.name_word1    = w.name1;
    req.name_word2    = w.name2;
    req.name_word3    = w.name3;
    req.slot_index    = w.idx;
    req.new_value     = w.value;
    req.new_type      = w.typ;
    req.new_arg_class = w.arg;
    req.valid         = 1'b1;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    pred = table_step(w);
    pending.push_back(w.typed ? w.want : pred);
    @(negedge clk_i);
  endtask

  task automatic settle();
    req.valid = 1'b0;
    while (pending.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [sht_pkg::CFG_IDX_W-1:0] idx,
                           logic [sht_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    if (idx == sht_pkg::CFG_SYMBOL_TYPE_CODE) new_sym_type = data[sht_pkg::CODE_W-1:0];
    else new_sym_value = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic run_random(int n, bit filling);
    for (int i = 0; i < n; i++) push_req(rand_req(filling));
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = '0;
    cfg_data_i        = '0;
    req.valid         = 1'b0;
    req.func          = sht_pkg::FUNC_INSERT;
    req.name_word0    = '0;
    req.name_word1    = '0;
    req.name_word2    = '0;
    req.name_word3    = '0;
    req.slot_index    = '0;
    req.new_value     = '0;
    req.new_type      = '0;
    req.new_arg_class = '0;
    rsp.ready         = 1'b0;
    for (int i = 0; i < TBL; i++) begin
      slot_names[i]  = '0;
      slot_values[i] = '0;
      slot_types[i]  = '0;
      slot_args[i]   = '0;
    end
    sym_count     = 0;
    new_sym_type  = sht_pkg::RESET_SYMBOL_TYPE;
    new_sym_value = sht_pkg::RESET_UNDEF_VALUE;

    add_name(sht_pkg::FUNC_INSERT, '0);
    pin_last(mk_res(sht_pkg::STATUS_EMPTY, 0, '0, 0, 0));
    add_name(sht_pkg::FUNC_SEARCH, {{29{8'hFF}}, 16'hFF00});
    pin_last(mk_res(sht_pkg::STATUS_EMPTY, 0, '0, 0, 0));
    add_slot(sht_pkg::FUNC_READ, 0, $urandom, 15, 15);
    pin_last(mk_res(sht_pkg::STATUS_FOUND, 0, '0, 0, 0));
    add_slot(sht_pkg::FUNC_READ, TBL - 1, $urandom, 7, 7);
    pin_last(mk_res(sht_pkg::STATUS_FOUND, TBL - 1, '0, 0, 0));
    add_slot(sht_pkg::FUNC_SET, TBL, 32'h1234_5678, 3, 3);
    pin_last(mk_res(sht_pkg::STATUS_BAD_INDEX, 0, '0, 0, 0));
    add_slot(sht_pkg::FUNC_READ, 1023, $urandom, 0, 0);
    pin_last(mk_res(sht_pkg::STATUS_BAD_INDEX, 0, '0, 0, 0));
    add_slot(sht_pkg::FUNC_SET, TBL - 1, 32'h8000_0000, 15, 15);
    pin_last(mk_res(sht_pkg::STATUS_FOUND, TBL - 1, 32'h8000_0000, 15, 15));
    add_slot(sht_pkg::FUNC_READ, TBL - 1, '0, 0, 0);
    pin_last(mk_res(sht_pkg::STATUS_FOUND, TBL - 1, 32'h8000_0000, 15, 15));
    add_slot(sht_pkg::FUNC_SET, 0, 32'h7FFF_FFFF, 0, 10);
    pin_last(mk_res(sht_pkg::STATUS_FOUND, 0, 32'h7FFF_FFFF, 0, 10));
    add_name(sht_pkg::FUNC_SEARCH, 248'h41);
    pin_last(mk_res(sht_pkg::STATUS_NOT_FOUND, 0, '0, 0, 0));
    add_name(sht_pkg::FUNC_INSERT, 248'h41);
    pin_last(mk_res(sht_pkg::STATUS_INSERTED, 65, '0, 2, 0));
    add_name(sht_pkg::FUNC_INSERT, 248'h41);
    pin_last(mk_res(sht_pkg::STATUS_FOUND, 65, '0, 2, 0));
    add_name(sht_pkg::FUNC_SEARCH, 248'hDEAD_BEEF_0041);
    add_name(sht_pkg::FUNC_INSERT, 248'h2120);
    add_slot(sht_pkg::FUNC_SET, TBL - 2, 32'd5, 1, 9);
    add_name(sht_pkg::FUNC_INSERT, 248'hFEFF_FFFF);
    add_name(sht_pkg::FUNC_INSERT, 248'hFFFF_FFFF);
    add_name(sht_pkg::FUNC_INSERT, 248'h01_FEFF_FFFF);
    add_name(sht_pkg::FUNC_INSERT, {31{8'hFF}});
    add_name(sht_pkg::FUNC_SEARCH, {31{8'hFF}});
    add_name(sht_pkg::FUNC_SEARCH, 248'h01_FEFF_FFFF);
    add_slot(sht_pkg::FUNC_READ, 66, '0, 0, 0);
    add_slot(sht_pkg::FUNC_SET, 65, 32'hFFFF_FFFF, 1, 3);
    add_name(sht_pkg::FUNC_SEARCH, 248'h41);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan_q[i]) push_req(plan_q[i]);

    settle();
    write_reg(sht_pkg::CFG_SYMBOL_TYPE_CODE, 32'hFFFF_FFFF);
    write_reg(sht_pkg::CFG_UNDEFINED_VALUE, 32'h8000_0000);
    run_random(350, 1'b0);

    settle();
    write_reg(sht_pkg::CFG_SYMBOL_TYPE_CODE, 32'hFFFF_FFF0);
    write_reg(sht_pkg::CFG_UNDEFINED_VALUE, 32'h7FFF_FFFF);
    run_random(350, 1'b0);

    // fill the table well past its limit
    settle();
    write_reg(sht_pkg::CFG_SYMBOL_TYPE_CODE, $urandom);
    write_reg(sht_pkg::CFG_UNDEFINED_VALUE, $urandom);
    run_random(750, 1'b1);

    settle();
    write_reg(sht_pkg::CFG_UNDEFINED_VALUE, $urandom);
    write_reg(sht_pkg::CFG_SYMBOL_TYPE_CODE, $urandom);
    run_random(250, 1'b0);

    settle();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    sht_pkg::result_t got;
    sht_pkg::result_t want;
    int stall;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = pick_wait(calm_rx);
      if (stall > 0) begin
        rsp.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp.ready = 1'b1;
      @(posedge clk_i);
      while (!rsp.valid) @(posedge clk_i);
      got.status         = rsp.status;
      got.found_index    = rsp.found_index;
      got.slot_value     = rsp.slot_value;
      got.slot_type      = rsp.slot_type;
      got.slot_arg_class = rsp.slot_arg_class;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: status %0d index %0d value %h type %0d arg %0d",
                   got.status, got.found_index, got.slot_value, got.slot_type,
                   got.slot_arg_class);
      end else begin
        want = pending.pop_front();
        if (got.status !== want.status || got.found_index !== want.found_index ||
            got.slot_value !== want.slot_value || got.slot_type !== want.slot_type ||
            got.slot_arg_class !== want.slot_arg_class) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at cycle %0d: want %0d/%0d/%h/%0d/%0d got %0d/%0d/%h/%0d/%0d",
                     cycles, want.status, want.found_index, want.slot_value,
                     want.slot_type, want.slot_arg_class, got.status, got.found_index,
                     got.slot_value, got.slot_type, got.slot_arg_class);
        end
      end
      @(negedge clk_i);
    end
  end

endmodule

// ===== files.f =====
design/sht_pkg.sv
design/sht_if.sv
design/sht_ram.sv
design/symbol_hash_table.sv
design/sht_checker.sv
dv/tb_symbol_hash_table.sv
